### hw/rtl/ppfl_pkg.sv
package ppfl_pkg;

    localparam int POOL_ENTRIES_DEF = 1024;
    localparam int MAX_RUN_DEF      = 64;

    localparam int OP_W     = 2;
    localparam int CNT_W    = 7;
    localparam int HANDLE_W = 10;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] POOL_SIZE_RST = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 11'd2047;

    localparam logic [OP_W-1:0] OP_RESET_ALL = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC     = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE      = 2'd2;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam int  PADDR_W       = 3;
    localparam logic REG_POOL_SIZE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_SINGLE,
        ST_POP_RD,
        ST_POP_WB
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [CNT_W-1:0]    alloc_count;
        logic [HANDLE_W-1:0] handle;
    } item_t;

    typedef struct packed {
        logic                status;
        logic [HANDLE_W-1:0] granted_handle;
        logic                last;
        logic [COUNT_W-1:0]  free_count;
        logic [COUNT_W-1:0]  lost_count;
    } result_t;

endpackage

### hw/rtl/point_pool_free_list_allocator.sv
// Free/unknown: one result; allocate of n (clamped to 1..MAX_RUN): one result per handle,
// ending early on empty; reset-all: sweeps pool_size (clamped to POOL_ENTRIES) entries,
// none when zero. Throughput: one item at a time; an allocate run streams one handle per
// cycle unless the output stalls, via the read-then-follow loop on the registered RAM read.
// Reset: aresetn (synchronous) empties the free list and sets pool_size to 1024;
// the link memory holds no defined contents until a reset-all operation sweeps it.
module point_pool_free_list_allocator #(
    parameter int POOL_ENTRIES = ppfl_pkg::POOL_ENTRIES_DEF,
    parameter int MAX_RUN      = ppfl_pkg::MAX_RUN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppfl_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,  // alloc_count[6:0], handle[16:7]
    input  logic [1:0]                    s_tuser,  // operation[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,  // granted_handle[9:0], free_count[20:10],
                                                    // lost_count[31:21]
    output logic [0:0]                    m_tuser,  // status[0]
    output logic                          m_tlast
);

    localparam int ADDR_W = $clog2(POOL_ENTRIES);
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);

    logic [ppfl_pkg::COUNT_W-1:0] pool_size_reg;
    logic                         cfg_sel;
    ppfl_pkg::item_t              in_item;
    ppfl_pkg::result_t            out_result;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [LINK_W-1:0]            ram_wdata;
    logic                         ram_re;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [LINK_W-1:0]            ram_rdata;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == ppfl_pkg::REG_POOL_SIZE);
    assign prdata  = cfg_sel ? 32'(pool_size_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_size_reg <= ppfl_pkg::POOL_SIZE_RST;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            pool_size_reg <= pwdata[ppfl_pkg::COUNT_W-1:0];
        end
    end

    assign in_item.operation   = s_tuser;
    assign in_item.alloc_count = s_tdata[6:0];
    assign in_item.handle      = s_tdata[16:7];

    ppfl_ctrl #(
        .POOL_ENTRIES(POOL_ENTRIES),
        .MAX_RUN     (MAX_RUN)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pool_size (pool_size_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_result(out_result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ppfl_ram #(
        .WIDTH(LINK_W),
        .DEPTH(POOL_ENTRIES)
    ) u_link_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign m_tdata  = {out_result.lost_count, out_result.free_count, out_result.granted_handle};
    assign m_tuser  = out_result.status;
    assign m_tlast  = out_result.last;

endmodule

### hw/rtl/ppfl_ram.sv
module ppfl_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ppfl_ctrl.sv
module ppfl_ctrl #(
    parameter int POOL_ENTRIES = ppfl_pkg::POOL_ENTRIES_DEF,
    parameter int MAX_RUN      = ppfl_pkg::MAX_RUN_DEF,
    localparam int ADDR_W      = $clog2(POOL_ENTRIES),
    localparam int LINK_W      = $clog2(POOL_ENTRIES + 1)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [ppfl_pkg::COUNT_W-1:0]    pool_size,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ppfl_pkg::item_t                 in_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ppfl_pkg::result_t               out_result,
    output logic                            ram_we,
    output logic [ADDR_W-1:0]               ram_waddr,
    output logic [LINK_W-1:0]               ram_wdata,
    output logic                            ram_re,
    output logic [ADDR_W-1:0]               ram_raddr,
    input  logic [LINK_W-1:0]               ram_rdata
);

    localparam int RUN_W = $clog2(MAX_RUN + 1);
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_ENTRIES);

    ppfl_pkg::state_t state_reg, state_next;
    logic [ppfl_pkg::OP_W-1:0]     op_reg, op_next;
    logic [RUN_W-1:0]              cnt_reg, cnt_next;
    logic [ppfl_pkg::HANDLE_W-1:0] h_reg, h_next;
    logic [LINK_W-1:0]             head_reg, head_next;
    logic [ppfl_pkg::COUNT_W-1:0]  total_reg, total_next;
    logic [ADDR_W-1:0]             sweep_reg, sweep_next;
    logic                          out_valid_reg, out_valid_next;
    ppfl_pkg::result_t             result_reg, result_next;

    logic [ppfl_pkg::COUNT_W-1:0]  eff_size;
    logic [RUN_W-1:0]              cnt_clamped;
    logic                          out_free;
    logic                          emit;
    logic                          e_status;
    logic [ppfl_pkg::HANDLE_W-1:0] e_grant;
    logic                          e_last;
    logic                          sweep_last;
    logic                          head_null;
    logic                          handle_ok;

    assign eff_size = (32'(pool_size) > POOL_ENTRIES) ?
                      ppfl_pkg::COUNT_W'(POOL_ENTRIES) : pool_size;
    assign out_free   = !out_valid_reg || out_ready;
    assign sweep_last = (32'(sweep_reg) + 32'd1 == 32'(eff_size));
    assign head_null  = (head_reg >= NULL_LINK);
    assign handle_ok  = (32'(h_reg) < POOL_ENTRIES);

    always_comb begin
        if (in_item.alloc_count == '0) begin
            cnt_clamped = RUN_W'(1);
        end else if (32'(in_item.alloc_count) > MAX_RUN) begin
            cnt_clamped = RUN_W'(MAX_RUN);
        end else begin
            cnt_clamped = RUN_W'(in_item.alloc_count);
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        h_next     = h_reg;
        head_next  = head_reg;
        total_next = total_reg;
        sweep_next = sweep_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        emit       = 1'b0;
        e_status   = ppfl_pkg::STATUS_OK;
        e_grant    = '0;
        e_last     = 1'b1;

        unique case (state_reg)
            ppfl_pkg::ST_IDLE: begin
                if (in_valid) begin
                    op_next    = in_item.operation;
                    cnt_next   = cnt_clamped;
                    h_next     = in_item.handle;
                    sweep_next = '0;
                    if (in_item.operation == ppfl_pkg::OP_RESET_ALL && eff_size != '0) begin
                        state_next = ppfl_pkg::ST_SWEEP;
                    end else if (in_item.operation == ppfl_pkg::OP_ALLOC) begin
                        state_next = ppfl_pkg::ST_POP_RD;
                    end else begin
                        state_next = ppfl_pkg::ST_SINGLE;
                    end
                end
            end
            ppfl_pkg::ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = sweep_last ? NULL_LINK : LINK_W'(sweep_reg) + LINK_W'(1);
                if (!sweep_last) begin
                    sweep_next = sweep_reg + ADDR_W'(1);
                end else if (out_free) begin
                    head_next  = '0;
                    total_next = eff_size;
                    emit       = 1'b1;
                    state_next = ppfl_pkg::ST_IDLE;
                end
            end
            ppfl_pkg::ST_SINGLE: begin
                if (out_free) begin
                    if (op_reg == ppfl_pkg::OP_FREE && handle_ok) begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(h_reg);
                        ram_wdata = head_reg;
                        head_next = LINK_W'(h_reg);
                        if (total_reg < ppfl_pkg::COUNT_MAX) begin
                            total_next = total_reg + ppfl_pkg::COUNT_W'(1);
                        end
                    end else if (op_reg == ppfl_pkg::OP_RESET_ALL) begin
                        head_next  = NULL_LINK;
                        total_next = '0;
                    end
                    emit       = 1'b1;
                    state_next = ppfl_pkg::ST_IDLE;
                end
            end
            ppfl_pkg::ST_POP_RD: begin
                if (head_null) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        e_status   = ppfl_pkg::STATUS_EMPTY;
                        state_next = ppfl_pkg::ST_IDLE;
                    end
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = ADDR_W'(head_reg);
                    state_next = ppfl_pkg::ST_POP_WB;
                end
            end
            ppfl_pkg::ST_POP_WB: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_grant   = ppfl_pkg::HANDLE_W'(head_reg);
                    e_last    = (cnt_reg == RUN_W'(1));
                    head_next = ram_rdata;
                    cnt_next  = cnt_reg - RUN_W'(1);
                    if (total_reg != '0) begin
                        total_next = total_reg - ppfl_pkg::COUNT_W'(1);
                    end
                    if (cnt_reg == RUN_W'(1)) begin
                        state_next = ppfl_pkg::ST_IDLE;
                    end else if (ram_rdata >= NULL_LINK) begin
                        state_next = ppfl_pkg::ST_POP_RD;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(ram_rdata);
                    end
                end
            end
            default: begin
                state_next = ppfl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        result_next = result_reg;
        if (emit) begin
            result_next.status         = e_status;
            result_next.granted_handle = e_grant;
            result_next.last           = e_last;
            result_next.free_count     = total_next;
            result_next.lost_count     = (eff_size > total_next) ? eff_size - total_next : '0;
        end
        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ppfl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            head_reg      <= NULL_LINK;
            total_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        h_reg      <= h_next;
        sweep_reg  <= sweep_next;
        result_reg <= result_next;
    end

    assign in_ready   = (state_reg == ppfl_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ppfl_pkg::ST_SWEEP || state_reg == ppfl_pkg::ST_SINGLE))
        else $error("link write outside sweep or push");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("link read and write in the same cycle");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != ppfl_pkg::ST_IDLE))
        else $error("item accepted but block stayed idle");

    a_run_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !result_reg.last) |->
        (state_reg == ppfl_pkg::ST_POP_RD || state_reg == ppfl_pkg::ST_POP_WB))
        else $error("non-final result while no run is open");

    a_empty_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && e_status == ppfl_pkg::STATUS_EMPTY) |-> head_null)
        else $error("pool empty reported with a live head");

endmodule
